// ----- src/bbu_pkg.sv -----
// Shared constants and types for the bit-banged 8N1 serial transceiver.
// No dependencies; every other file takes names from here by scope.
package bbu_pkg;

	localparam int PERIOD_W        = 20;   // width of the bit period register
	localparam int COUNT_W_DEFAULT = 20;   // default tick/sample counter width
	localparam int SHIFT_W         = 16;   // rx and tx shift registers
	localparam int BITS_W          = 4;    // bit counters
	localparam int BYTE_W          = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd100;
	localparam logic [BITS_W-1:0]   RX_LAST_BIT  = 4'd8;   // start + 8 data, index 0..8
	localparam logic [BITS_W-1:0]   TX_LAST_BIT  = 4'd10;  // runs through count 10
	localparam logic [BYTE_W-1:0]   IDLE_BYTE    = 8'hFF;
	localparam logic [SHIFT_W-1:0]  IDLE_SHIFT   = 16'hFFFF;
	localparam logic [SHIFT_W-1:0]  TX_SHIFT_RST = 16'h0001;
	localparam logic [6:0]          STOP_FILL    = 7'h7F;  // stop bit and idle ones above data

	// transmit-side events of one word
	typedef struct packed {
		logic              open_line;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
	} tx_evt_t;

	typedef struct packed {
		logic              byte_ready;
		logic [BYTE_W-1:0] rx_byte;
		logic              rx_seen;
	} rx_status_t;

	typedef struct packed {
		logic tx_line;
		logic transmitting;
		logic tx_seen;
	} tx_status_t;

endpackage

// ----- src/bbu_if.sv -----
// Valid/ready channel interfaces for input words and result words.
// Depends on bbu_pkg for field widths.
interface bbu_in_if;
	logic                       valid;
	logic                       ready;
	logic                       rx_line;
	logic                       send_valid;
	logic [bbu_pkg::BYTE_W-1:0] send_byte;
	logic                       recv_ack;
	logic                       open_line;

	modport source (output valid, rx_line, send_valid, send_byte, recv_ack, open_line,
		input ready);
	modport sink (input valid, rx_line, send_valid, send_byte, recv_ack, open_line,
		output ready);
endinterface

interface bbu_out_if;
	logic                       valid;
	logic                       ready;
	logic                       tx_line;
	logic                       byte_ready;
	logic [bbu_pkg::BYTE_W-1:0] rx_byte;
	logic                       transmitting;
	logic                       rx_seen;
	logic                       tx_seen;

	modport source (output valid, tx_line, byte_ready, rx_byte, transmitting, rx_seen,
		tx_seen, input ready);
	modport sink (input valid, tx_line, byte_ready, rx_byte, transmitting, rx_seen,
		tx_seen, output ready);
endinterface

// ----- src/bbu_rx.sv -----
// Receiver: falling-edge start detect, majority vote per bit window, byte latch.
// Depends on bbu_pkg.
module bbu_rx #(
	parameter int COUNT_W = bbu_pkg::COUNT_W_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic                         rx_line,
	input  logic                         recv_ack,
	input  logic [bbu_pkg::PERIOD_W-1:0] bit_period,
	output bbu_pkg::rx_status_t          status
);

	localparam int CMP_W = (COUNT_W > bbu_pkg::PERIOD_W) ? COUNT_W : bbu_pkg::PERIOD_W;

	logic                         prev_rx_q;
	logic [bbu_pkg::SHIFT_W-1:0]  shift_q;
	logic [bbu_pkg::BITS_W-1:0]   bits_q;
	logic [COUNT_W-1:0]           ticks_q;
	logic [COUNT_W-1:0]           ones_q;
	logic [bbu_pkg::BYTE_W-1:0]   data_q;
	logic                         ready_q;
	logic                         seen_q;

	logic [bbu_pkg::SHIFT_W-1:0]  shift_d;
	logic [bbu_pkg::BITS_W-1:0]   bits_d;
	logic [COUNT_W-1:0]           ticks_d;
	logic [COUNT_W-1:0]           ones_d;
	logic [bbu_pkg::BYTE_W-1:0]   data_d;
	logic                         ready_d;
	logic                         seen_d;
	logic [COUNT_W-1:0]           ticks_inc;
	logic [COUNT_W-1:0]           ones_inc;
	logic                         vote;

	assign ticks_inc = ticks_q + 1'b1;
	assign ones_inc  = rx_line ? ones_q + 1'b1 : ones_q;
	assign vote      = CMP_W'(ones_inc) > CMP_W'(bit_period >> 1);

	always_comb begin
		shift_d = shift_q;
		bits_d  = bits_q;
		ticks_d = ticks_q;
		ones_d  = ones_q;
		data_d  = data_q;
		ready_d = recv_ack ? 1'b0 : ready_q;
		seen_d  = seen_q;
		if (ticks_q != '0) begin
			if (CMP_W'(ticks_inc) >= CMP_W'(bit_period)) begin
				// window closed: decide the bit
				ticks_d = COUNT_W'(1);
				ones_d  = '0;
				shift_d = {vote, shift_q[bbu_pkg::SHIFT_W-1:1]};
				bits_d  = bits_q + 1'b1;
				if (bits_d > bbu_pkg::RX_LAST_BIT) begin
					data_d  = shift_d[bbu_pkg::SHIFT_W-1 -: bbu_pkg::BYTE_W];
					ready_d = 1'b1;
					ticks_d = '0;
					bits_d  = '0;
				end
			end else begin
				ticks_d = ticks_inc;
				ones_d  = ones_inc;
			end
		end else if (prev_rx_q && !rx_line) begin
			ticks_d = COUNT_W'(1);
			bits_d  = '0;
			shift_d = '0;
			ones_d  = '0;
			seen_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rx_q <= 1'b1;
			shift_q   <= '0;
			bits_q    <= '0;
			ticks_q   <= '0;
			ones_q    <= '0;
			data_q    <= '0;
			ready_q   <= 1'b0;
			seen_q    <= 1'b0;
		end else if (step) begin
			prev_rx_q <= rx_line;
			shift_q   <= shift_d;
			bits_q    <= bits_d;
			ticks_q   <= ticks_d;
			ones_q    <= ones_d;
			data_q    <= data_d;
			ready_q   <= ready_d;
			seen_q    <= seen_d;
		end
	end

	assign status.byte_ready = ready_q;
	assign status.rx_byte    = data_q;
	assign status.rx_seen    = seen_q;

endmodule

// ----- src/bbu_tx.sv -----
// Transmitter: pending byte latch, frame shifter paced by the bit period.
// Depends on bbu_pkg.
module bbu_tx #(
	parameter int COUNT_W = bbu_pkg::COUNT_W_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  bbu_pkg::tx_evt_t             evt,
	input  logic [bbu_pkg::PERIOD_W-1:0] bit_period,
	output bbu_pkg::tx_status_t          status
);

	localparam int CMP_W = (COUNT_W > bbu_pkg::PERIOD_W) ? COUNT_W : bbu_pkg::PERIOD_W;

	logic [bbu_pkg::SHIFT_W-1:0] shift_q, shift_d, shift_e;
	logic [bbu_pkg::BITS_W-1:0]  bits_q, bits_d, bits_e;
	logic [COUNT_W-1:0]          ticks_q, ticks_d, ticks_e, ticks_inc;
	logic                        pend_q, pend_d, pend_e;
	logic [bbu_pkg::BYTE_W-1:0]  pbyte_q, pbyte_d;
	logic                        seen_q, seen_d;

	// word events first: open, then send
	always_comb begin
		shift_e = shift_q;
		bits_e  = bits_q;
		ticks_e = ticks_q;
		pbyte_d = pbyte_q;
		pend_e  = pend_q;
		if (evt.open_line) begin
			pbyte_d = bbu_pkg::IDLE_BYTE;
			bits_e  = bbu_pkg::BITS_W'(1);
			shift_e = bbu_pkg::IDLE_SHIFT;
			ticks_e = '0;
		end
		if (evt.send_valid) begin
			pbyte_d = evt.send_byte;
			pend_e  = 1'b1;
		end
	end

	assign ticks_inc = ticks_e + 1'b1;

	always_comb begin
		shift_d = shift_e;
		bits_d  = bits_e;
		ticks_d = ticks_e;
		pend_d  = pend_e;
		seen_d  = seen_q;
		if (bits_e == '0) begin
			if (pend_e) begin
				pend_d  = 1'b0;
				seen_d  = 1'b1;
				bits_d  = bbu_pkg::BITS_W'(1);
				shift_d = {bbu_pkg::STOP_FILL, pbyte_d, 1'b0};
				ticks_d = '0;
			end
		end else if (CMP_W'(ticks_inc) >= CMP_W'(bit_period)) begin
			ticks_d = '0;
			shift_d = shift_e >> 1;
			bits_d  = bits_e + 1'b1;
			if (bits_d > bbu_pkg::TX_LAST_BIT) begin
				bits_d = '0;
			end
		end else begin
			ticks_d = ticks_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= bbu_pkg::TX_SHIFT_RST;
			bits_q  <= '0;
			ticks_q <= '0;
			pend_q  <= 1'b0;
			pbyte_q <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			shift_q <= shift_d;
			bits_q  <= bits_d;
			ticks_q <= ticks_d;
			pend_q  <= pend_d;
			pbyte_q <= pbyte_d;
			seen_q  <= seen_d;
		end
	end

	assign status.tx_line      = shift_q[0];
	assign status.transmitting = (bits_q != '0);
	assign status.tx_seen      = seen_q;

endmodule

// ----- src/bitbang_uart_transceiver_top.sv -----
// Top level of the bit-banged 8N1 serial transceiver.
// Depends on bbu_pkg, bbu_if, bbu_rx and bbu_tx.
//
// Each input word is one tick of the serial line: the sampled rx level plus
// optional open, send and receive-acknowledge events, applied in that order
// before the tick. Each word yields exactly one result word showing the line
// and status after that tick. Throughput is one word per clock while the result
// slot is not stalled; a word is captured in the input register at acceptance,
// and its result is registered when it moves on from there. The receiver
// and transmitter state registers double as the result register: they advance
// only when the result slot is empty or being taken, so a stalled result
// simply holds while one more word waits in the input register. bit_period
// (reset 100) may only be written while the block is idle; a value of zero
// behaves as one tick per bit. Tick and sample counters are COUNT_W bits
// wide and wrap. The stop bit is not checked on receive, and a byte arriving
// while byte_ready is set overwrites rx_byte.
module bitbang_uart_transceiver_top #(
	parameter int COUNT_W = bbu_pkg::COUNT_W_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bbu_pkg::PERIOD_W-1:0] cfg_wr_data,
	bbu_in_if.sink                       item,
	bbu_out_if.source                    result
);

	logic [bbu_pkg::PERIOD_W-1:0] bit_period_q;

	// input register
	logic             valid_s1;
	logic             rx_s1;
	logic             ack_s1;
	bbu_pkg::tx_evt_t evt_s1;

	logic                res_valid_q;
	logic                step;
	logic                accept;
	bbu_pkg::rx_status_t rx_stat;
	bbu_pkg::tx_status_t tx_stat;

	// the held word moves on when the result slot is free or drains this cycle
	assign step       = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || step;
	assign accept     = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= bbu_pkg::PERIOD_RESET;
		end else if (cfg_wr_en) begin
			bit_period_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			rx_s1                <= item.rx_line;
			ack_s1               <= item.recv_ack;
			evt_s1.open_line     <= item.open_line;
			evt_s1.send_valid    <= item.send_valid;
			evt_s1.send_byte     <= item.send_byte;
		end
	end

	bbu_rx #(.COUNT_W(COUNT_W)) u_rx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_line    (rx_s1),
		.recv_ack   (ack_s1),
		.bit_period (bit_period_q),
		.status     (rx_stat)
	);

	bbu_tx #(.COUNT_W(COUNT_W)) u_tx (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.evt        (evt_s1),
		.bit_period (bit_period_q),
		.status     (tx_stat)
	);

	assign result.valid        = res_valid_q;
	assign result.tx_line      = tx_stat.tx_line;
	assign result.byte_ready   = rx_stat.byte_ready;
	assign result.rx_byte      = rx_stat.rx_byte;
	assign result.transmitting = tx_stat.transmitting;
	assign result.rx_seen      = rx_stat.rx_seen;
	assign result.tx_seen      = tx_stat.tx_seen;

endmodule

// ----- src/bbu_chk.sv -----
// Port-level checker for the transceiver top, attached by bind.
// Depends on bbu_pkg and the top level's port list.
module bbu_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic                       byte_ready,
	input logic [bbu_pkg::BYTE_W-1:0] rx_byte,
	input logic                       rx_seen,
	input logic                       tx_seen
);

	logic rx_seen_q;
	logic tx_seen_q;

	// sticky flags as shown in words already taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_seen_q <= 1'b0;
			tx_seen_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			rx_seen_q <= rx_seen_q | rx_seen;
			tx_seen_q <= tx_seen_q | tx_seen;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(rx_byte))
		else $error("result word dropped or changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result slot");

	a_ready_implies_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_ready |-> rx_seen)
		else $error("byte_ready without any start bit seen");

	a_rx_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rx_seen_q |-> rx_seen)
		else $error("rx_seen cleared");

	a_tx_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tx_seen_q |-> tx_seen)
		else $error("tx_seen cleared");

endmodule

bind bitbang_uart_transceiver_top bbu_chk u_bbu_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (item.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.byte_ready (result.byte_ready),
	.rx_byte    (result.rx_byte),
	.rx_seen    (result.rx_seen),
	.tx_seen    (result.tx_seen)
);

// ----- bench/tb_bitbang_uart_transceiver_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bitbang_uart_transceiver_top: serial line ticks in, line status out.
// Depends on bbu_pkg, bbu_if and the RTL under src; predicts every status word internally.
module tb_bitbang_uart_transceiver_top;

	localparam int PERIOD_W        = bbu_pkg::PERIOD_W;
	localparam int SHIFT_W         = bbu_pkg::SHIFT_W;
	localparam int BITS_W          = bbu_pkg::BITS_W;
	localparam int BYTE_W          = bbu_pkg::BYTE_W;
	localparam int COUNT_W_DEFAULT = bbu_pkg::COUNT_W_DEFAULT;

	localparam int WATCHDOG_LIMIT = 2000;   // cycles with no word moving on either side
	localparam int SETTLE_CYCLES  = 4;      // margin after the drain before a period write
	localparam int TAIL_CYCLES    = 8;
	localparam int SEGMENT_TICKS  = 108;    // random ticks per period setting and idle phase

	// One input word: a single tick of the line plus its events.
	typedef struct packed {
		logic              rx_line;
		logic              send_valid;
		logic [BYTE_W-1:0] send_byte;
		logic              recv_ack;
		logic              open_line;
	} line_tick_t;

	// One result word: line and status after the tick.
	typedef struct packed {
		logic              tx_line;
		logic              byte_ready;
		logic [BYTE_W-1:0] rx_byte;
		logic              transmitting;
		logic              rx_seen;
		logic              tx_seen;
	} line_status_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [PERIOD_W-1:0] cfg_wr_data;

	bbu_in_if  tick_in ();
	bbu_out_if status_out ();

	bitbang_uart_transceiver_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item       (tick_in),
		.result     (status_out)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Stimulus and scoreboard storage
	line_tick_t   tick_backlog[$];   // words waiting for the driver
	line_status_t status_expect[$];  // predicted status words, oldest first
	int unsigned  words_queued;
	int unsigned  words_taken;
	int unsigned  mismatches;
	int unsigned  stall_cycles;
	int unsigned  send_idle_pct;
	int unsigned  recv_stall_pct;
	bit           took_word;
	bit           took_result;

	// Predictor state. Counters run at the block's default counter width.
	logic [PERIOD_W-1:0]        period_q;
	logic                       prev_rx_q;
	logic [SHIFT_W-1:0]         rx_sr;
	logic [BITS_W-1:0]          rx_bit_cnt;
	logic [COUNT_W_DEFAULT-1:0] rx_tick_cnt;
	logic [COUNT_W_DEFAULT-1:0] rx_high_cnt;
	logic [BYTE_W-1:0]          rx_byte_q;
	logic                       ready_q;
	logic [SHIFT_W-1:0]         tx_sr;
	logic [BITS_W-1:0]          tx_bit_cnt;
	logic [COUNT_W_DEFAULT-1:0] tx_tick_cnt;
	logic                       pend_q;
	logic [BYTE_W-1:0]          pend_byte;
	logic                       rx_seen_q;
	logic                       tx_seen_q;

	function automatic void reset_line_model();
		period_q    = 20'd100;
		prev_rx_q   = 1'b1;
		rx_sr       = '0;
		rx_bit_cnt  = '0;
		rx_tick_cnt = '0;
		rx_high_cnt = '0;
		rx_byte_q   = '0;
		ready_q     = 1'b0;
		tx_sr       = 16'h0001;
		tx_bit_cnt  = '0;
		tx_tick_cnt = '0;
		pend_q      = 1'b0;
		pend_byte   = '0;
		rx_seen_q   = 1'b0;
		tx_seen_q   = 1'b0;
	endfunction

	// Advances the line model by one tick and returns the status after it.
	function automatic line_status_t step_line_model(line_tick_t w);
		line_status_t s;
		// events first: open, then send, then acknowledge
		if (w.open_line) begin
			pend_byte   = 8'hFF;
			tx_bit_cnt  = 4'd1;
			tx_sr       = 16'hFFFF;
			tx_tick_cnt = '0;
		end
		if (w.send_valid) begin
			pend_byte = w.send_byte;
			pend_q    = 1'b1;
		end
		if (w.recv_ack)
			ready_q = 1'b0;

		// receiver: falling edge opens a frame, then majority vote per window
		if (rx_tick_cnt != 0) begin
			rx_tick_cnt = rx_tick_cnt + 1'b1;
			if (w.rx_line)
				rx_high_cnt = rx_high_cnt + 1'b1;
			if (rx_tick_cnt >= period_q) begin
				rx_tick_cnt = COUNT_W_DEFAULT'(1);
				rx_sr       = {rx_high_cnt > (period_q >> 1), rx_sr[SHIFT_W-1:1]};
				rx_bit_cnt  = rx_bit_cnt + 1'b1;
				rx_high_cnt = '0;
				if (rx_bit_cnt > 4'd8) begin
					rx_byte_q   = rx_sr[15:8];
					ready_q     = 1'b1;
					rx_tick_cnt = '0;
					rx_bit_cnt  = '0;
				end
			end
		end else if (prev_rx_q && !w.rx_line) begin
			rx_tick_cnt = COUNT_W_DEFAULT'(1);
			rx_bit_cnt  = '0;
			rx_sr       = '0;
			rx_high_cnt = '0;
			rx_seen_q   = 1'b1;
		end
		prev_rx_q = w.rx_line;

		// transmitter: load start/data/stop when idle, shift once per period
		if (tx_bit_cnt == 0) begin
			if (pend_q) begin
				pend_q      = 1'b0;
				tx_seen_q   = 1'b1;
				tx_bit_cnt  = 4'd1;
				tx_sr       = {7'h7F, pend_byte, 1'b0};
				tx_tick_cnt = '0;
			end
		end else begin
			tx_tick_cnt = tx_tick_cnt + 1'b1;
			if (tx_tick_cnt >= period_q) begin
				tx_tick_cnt = '0;
				tx_sr       = tx_sr >> 1;
				tx_bit_cnt  = tx_bit_cnt + 1'b1;
				if (tx_bit_cnt > 4'd10)
					tx_bit_cnt = '0;
			end
		end

		s.tx_line      = tx_sr[0];
		s.byte_ready   = ready_q;
		s.rx_byte      = rx_byte_q;
		s.transmitting = (tx_bit_cnt != 0);
		s.rx_seen      = rx_seen_q;
		s.tx_seen      = tx_seen_q;
		return s;
	endfunction

	function automatic void check_field(string name, logic [BYTE_W-1:0] want,
			logic [BYTE_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// Driver: new word, hold or idle gap at the falling edge, random stalls on the result side.
	always @(negedge clk) begin : word_driver
		line_tick_t w;
		if (arst_n && (!tick_in.valid || took_word)) begin
			if (tick_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				w = tick_backlog.pop_front();
				tick_in.valid      <= 1'b1;
				tick_in.rx_line    <= w.rx_line;
				tick_in.send_valid <= w.send_valid;
				tick_in.send_byte  <= w.send_byte;
				tick_in.recv_ack   <= w.recv_ack;
				tick_in.open_line  <= w.open_line;
			end else begin
				tick_in.valid <= 1'b0;
			end
		end
		status_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Monitor: everything is sampled at the rising edge, after the falling-edge drive settled.
	always @(posedge clk) begin : word_monitor
		line_status_t got;
		line_status_t want;
		if (!arst_n) begin
			reset_line_model();
			took_word    = 1'b0;
			took_result  = 1'b0;
			stall_cycles = 0;
		end else begin
			took_word   = tick_in.valid && tick_in.ready;
			took_result = status_out.valid && status_out.ready;
			if (cfg_wr_en)
				period_q = cfg_wr_data;
			if (took_result) begin
				got.tx_line      = status_out.tx_line;
				got.byte_ready   = status_out.byte_ready;
				got.rx_byte      = status_out.rx_byte;
				got.transmitting = status_out.transmitting;
				got.rx_seen      = status_out.rx_seen;
				got.tx_seen      = status_out.tx_seen;
				if (status_expect.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected status word, expected none actual %0h",
						$time, got);
				end else begin
					want = status_expect.pop_front();
					check_field("tx_line", want.tx_line, got.tx_line);
					check_field("byte_ready", want.byte_ready, got.byte_ready);
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("transmitting", want.transmitting, got.transmitting);
					check_field("rx_seen", want.rx_seen, got.rx_seen);
					check_field("tx_seen", want.tx_seen, got.tx_seen);
				end
			end
			if (took_word) begin
				words_taken++;
				status_expect.push_back(step_line_model({tick_in.rx_line,
					tick_in.send_valid, tick_in.send_byte, tick_in.recv_ack,
					tick_in.open_line}));
			end
			if (took_word || took_result)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// Watchdog: nothing moving for too long means a hang.
	initial begin
		wait (stall_cycles >= WATCHDOG_LIMIT);
		$display("bitbang_uart_transceiver_top regression: fail");
		$finish;
	end

	function automatic void push_word(logic rx, logic sv, logic [BYTE_W-1:0] data,
			logic ack, logic opn);
		tick_backlog.push_back({rx, sv, data, ack, opn});
		words_queued++;
	endfunction

	// A tick with the given rx level and sparse random events.
	function automatic void push_tick(logic rx);
		logic [BYTE_W-1:0] data;
		data = BYTE_W'($urandom);
		push_word(rx, $urandom_range(39) == 0, data, $urandom_range(15) == 0,
			$urandom_range(299) == 0);
	endfunction

	// Mostly clean 8N1 frames at the configured bit length, with noise and glitches.
	task automatic queue_serial_frames(input int unsigned ticks, input int unsigned bit_len);
		int unsigned       target;
		logic [9:0]        frame_bits;
		logic              lvl;
		logic [BYTE_W-1:0] data;
		target = words_queued + ticks;
		while (words_queued < target) begin
			if ($urandom_range(99) < 80) begin
				data       = BYTE_W'($urandom_range(255));
				frame_bits = {1'b1, data, 1'b0};   // stop, data LSB first, start
				for (int b = 0; b < 10; b++)
					for (int k = 0; k < bit_len; k++) begin
						lvl = frame_bits[b];
						if ($urandom_range(49) == 0)
							lvl = ~lvl;   // glitch inside a bit
						push_tick(lvl);
					end
				repeat ($urandom_range(3))
					push_tick(1'b1);
			end else begin
				repeat ($urandom_range(1, 8))
					push_tick(1'($urandom_range(1)));
			end
		end
	endtask

	// Every word sent and every status word back; checked at the falling edge.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (words_taken != words_queued || status_expect.size() != 0);
	endtask

	task automatic write_bit_period(input logic [PERIOD_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		int unsigned periods[4];
		periods = '{1, 4, 0, 2};

		// every input known from time zero
		arst_n                = 1'b0;
		cfg_wr_en             = 1'b0;
		cfg_wr_data           = '0;
		tick_in.valid         = 1'b0;
		tick_in.rx_line       = 1'b1;
		tick_in.send_valid    = 1'b0;
		tick_in.send_byte     = '0;
		tick_in.recv_ack      = 1'b0;
		tick_in.open_line     = 1'b0;
		status_out.ready      = 1'b0;
		words_queued          = 0;
		words_taken           = 0;
		mismatches            = 0;
		send_idle_pct         = 0;
		recv_stall_pct        = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed, at the reset period: each event alone, then all of them on one tick.
		push_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		push_word(1'b1, 1'b1, 8'h00, 1'b0, 1'b0);   // send all-zero byte
		push_word(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);   // ack with nothing waiting
		push_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b1);   // open: idle frame on tx
		push_word(1'b0, 1'b1, 8'hFF, 1'b0, 1'b0);   // rx falls: start bit seen
		push_word(1'b0, 1'b1, 8'h80, 1'b1, 1'b1);   // open, send and ack together
		push_word(1'b1, 1'b1, 8'h01, 1'b0, 1'b0);
		push_word(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);

		// Largest period, picked up mid-frame on both sides.
		write_bit_period(20'hFFFFF);
		push_word(1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		push_word(1'b0, 1'b1, 8'hA5, 1'b0, 1'b0);
		push_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		push_word(1'b0, 1'b0, 8'h00, 1'b0, 1'b1);
		push_word(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);

		// Zero period: one tick per bit, a whole frame of 0xAA.
		write_bit_period(20'd0);
		push_word(1'b1, 1'b1, 8'hC3, 1'b0, 1'b0);
		push_word(1'b1, 1'b0, 8'h00, 1'b0, 1'b0);
		push_word(1'b0, 1'b0, 8'h00, 1'b0, 1'b0);   // start
		for (int b = 0; b < 8; b++)
			push_word(b[0] ^ 1'b0 ? 1'b1 : 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
		push_word(1'b1, 1'b0, 8'h00, 1'b1, 1'b0);   // stop, with ack

		// Random traffic: four idle patterns, each over several bit periods.
		// Every segment drains fully before the next write, so the sender sits
		// idle until all expected status words are back.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 64;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 64;
				end
				default: begin
					send_idle_pct  = 6;
					recv_stall_pct = 6;
				end
			endcase
			for (int p = 0; p < 4; p++) begin
				write_bit_period(PERIOD_W'(periods[p]));
				queue_serial_frames(SEGMENT_TICKS, (periods[p] == 0) ? 1 : periods[p]);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("bitbang_uart_transceiver_top regression: pass");
		else
			$display("bitbang_uart_transceiver_top regression: fail");
		$finish;
	end

endmodule
